// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by the particle pool tick engine.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold on every clock edge outside reset.
`define PPTK_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Condition must never be seen on a clock edge outside reset.
`define PPTK_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define PPTK_ASSERT(lbl, clk, rstn, prop, msg)
`define PPTK_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

// ===== design/pptk_pkg.sv =====
// ---------------------------------------------------------------------------
// Particle pool package
// Shared types and constants of the particle pool tick engine.
// ---------------------------------------------------------------------------
package pptk_pkg;

  localparam int POOL_DEPTH = 64;
  localparam int SLOT_W     = 6;
  localparam int CNT_W      = 7;
  localparam int ACC_W      = 25;
  localparam int MUL_A_W    = 25;
  localparam int MUL_B_W    = 18;
  localparam int MUL_P_W    = MUL_A_W + MUL_B_W;

  localparam logic [ACC_W-1:0] ACC_MAX = '1;

  // One pool entry as held in the particle memory.
  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] speed;
    logic signed [15:0] accel;
    logic        [15:0] angle;
    logic        [23:0] life;
  } part_t;

  typedef enum logic [2:0] {
    FN_TICK  = 3'd0,
    FN_EMIT  = 3'd1,
    FN_START = 3'd2,
    FN_PAUSE = 3'd3,
    FN_STOP  = 3'd4
  } func_t;

  typedef enum logic [2:0] {
    CFG_POSITION  = 3'd0,
    CFG_SPREAD    = 3'd1,
    CFG_DIRECTION = 3'd2,
    CFG_LIFETIME  = 3'd3,
    CFG_ACCEL     = 3'd4,
    CFG_SPEED     = 3'd5,
    CFG_PERIOD    = 3'd6
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UPD_RD,
    S_UPD_CALC,
    S_CMP_RD,
    S_CMP_CHK,
    S_CMP_MOV,
    S_EMIT_CHK,
    S_SPAWN,
    S_OUT_RD,
    S_OUT_LD,
    S_OUT_ONE
  } state_t;

endpackage

// ===== design/particle_pool_tick_engine_unit.sv =====
// ---------------------------------------------------------------------------
// Particle pool tick engine
// Fixed pool of particles held in one memory, aged, moved and compacted on a
// tick, with timed and commanded emission from configured spans.
// ---------------------------------------------------------------------------
// Channel  Direction  Transfer                   Payload
// in_      slave      in_tvalid & in_tready      command, dt and six randoms
// out_     master     out_tvalid & out_tready    one result, tlast on final
// cfg_     slave      cfg_valid & cfg_ready      register index and data
//
// One command is worked at a time; in_tready is high only while idle.
// A tick updates each live particle in turn (one shared multiplier, 13
// products per particle), compacts the pool slot by slot, may make an
// automatic emission and then sends one result per live particle, or one
// result with no particle if the pool is empty. The last result of a command
// may still wait in the output register while the next command is taken.
// Reset is synchronous and active low; the memory needs no clearing pass, as
// only slots below the live count are ever read.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module particle_pool_tick_engine_unit
  import pptk_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [2:0] func, [18:3] dt, [34:19] rand_x, [50:35] rand_y, [66:51] rand_dir,
  // [82:67] rand_accel, [98:83] rand_vel, [114:99] rand_life, rest zero
  input  logic [119:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [5:0] slot, [29:6] pos_x, [53:30] pos_y, [77:54] life_left,
  // [84:78] live_count, rest zero
  output logic [87:0]  out_tdata,
  // [0] valid_res, [1] emit_dropped
  output logic [1:0]   out_tuser,
  output logic         out_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [47:0]  cfg_data
);

  // Saturate to the signed 24-bit range.
  function automatic logic signed [23:0] sat24(input logic signed [31:0] v);
    if (v > 32'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (v < -32'sd8388608) begin
      return 24'sh800000;
    end else begin
      return v[23:0];
    end
  endfunction

  // Configuration registers.
  logic [31:0] pos_r, spread_r, dir_r, accel_span_r, speed_span_r;
  logic [47:0] life_span_r;
  logic [23:0] period_r;

  // Sequencer control.
  state_t           state_r, state_nxt;
  logic [3:0]       st_r, st_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] live_r, live_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic             run_r, run_nxt;
  logic             drop_r, drop_nxt;

  // Latched command payload.
  logic [2:0]  func_r;
  logic [15:0] dt_r, rx_r, ry_r, rdir_r, racc_r, rvel_r, rlife_r;

  // Working entry and intermediate values.
  part_t              w_r, w_nxt;
  logic [15:0]        p_r, p_nxt;
  logic signed [16:0] cs_r, cs_nxt, sn_r, sn_nxt;
  logic signed [31:0] cdx_r, cdx_nxt, cdy_r, cdy_nxt;
  logic signed [MUL_P_W-1:0] lo_r, lo_nxt;

  // Output register.
  logic        out_tvalid_r, out_tvalid_nxt;
  logic        out_tlast_r, out_tlast_nxt;
  logic [87:0] out_tdata_r, out_tdata_nxt;
  logic [1:0]  out_tuser_r, out_tuser_nxt;

  // Memory and multiplier hookup.
  logic              mem_we, mem_re;
  logic [SLOT_W-1:0] mem_waddr, mem_raddr;
  part_t             mem_wdata, rd;
  logic                      mul_en;
  logic signed [MUL_A_W-1:0] a_op;
  logic signed [MUL_B_W-1:0] b_op;
  logic signed [MUL_P_W-1:0] prod;

  pptk_pool_mem u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .re      (mem_re),
    .raddr   (mem_raddr),
    .rdata_r (rd)
  );

  pptk_mul u_mul (
    .clk    (clk),
    .en     (mul_en),
    .a      (a_op),
    .b      (b_op),
    .prod_r (prod)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

  // Sine approximation helpers: magnitude of the angle taken as signed.
  logic [15:0] ang_c;
  logic [16:0] m_c, m_s;
  logic [15:0] pv, qv;
  assign ang_c = w_r.angle + 16'd16384;
  assign m_c   = ang_c[15] ? (17'h10000 - {1'b0, ang_c}) : {1'b0, ang_c};
  assign m_s   = w_r.angle[15] ? (17'h10000 - {1'b0, w_r.angle}) : {1'b0, w_r.angle};
  assign pv    = prod[28:13];
  assign qv    = p_r - prod[30:15];

  // Position integration: speed times (trig times dt), from two half products.
  logic signed [59:0] full_w;
  logic signed [59:0] dpos_w;
  assign full_w = (60'(prod) <<< 16) + 60'(lo_r);
  assign dpos_w = full_w >>> 31;

  // Spawn helpers.
  logic [16:0]        d_dir;
  logic [16:0]        d_acc, d_vel;
  logic [24:0]        d_life;
  logic signed [26:0] draw_w;
  logic [15:0]        vdraw;
  assign d_dir  = {1'b0, dir_r[31:16]} - {1'b0, dir_r[15:0]};
  assign d_acc  = {accel_span_r[31], accel_span_r[31:16]}
                - {accel_span_r[15], accel_span_r[15:0]};
  assign d_vel  = {speed_span_r[31], speed_span_r[31:16]}
                - {speed_span_r[15], speed_span_r[15:0]};
  assign d_life = {1'b0, life_span_r[47:24]} - {1'b0, life_span_r[23:0]};
  assign draw_w = 27'(prod >>> 16);
  assign vdraw  = speed_span_r[15:0] + draw_w[15:0];

  logic signed [31:0] spx_w, spy_w, spd_w;
  assign spx_w = 32'(signed'({pos_r[15:0], 8'b0})) + 32'(prod[31:7])
               - 32'({spread_r[15:0], 8'b0});
  assign spy_w = 32'(signed'({pos_r[31:16], 8'b0})) + 32'(prod[31:7])
               - 32'({spread_r[31:16], 8'b0});
  assign spd_w = 32'(w_r.speed) + 32'(prod >>> 12);

  // Emission accumulator.
  logic [ACC_W:0]   acc_sum;
  logic [ACC_W-1:0] acc_sat;
  assign acc_sum = {1'b0, acc_r} + (ACC_W+1)'(dt_r);
  assign acc_sat = acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];

  logic [CNT_W-1:0] live_m1;
  logic             out_free;
  assign live_m1  = live_r - 1'b1;
  assign out_free = !out_tvalid_r || out_tready;

  // Multiplier operand selection per step.
  always_comb begin
    mul_en = 1'b0;
    a_op   = '0;
    b_op   = '0;
    if (state_r == S_UPD_CALC) begin
      mul_en = 1'b1;
      case (st_r)
        4'd1: begin
          a_op = {{9{w_r.accel[15]}}, w_r.accel};
          b_op = {2'b0, dt_r};
        end
        4'd2: begin
          a_op = {8'b0, m_c};
          b_op = {1'b0, 17'h08000 - m_c};
        end
        4'd5: begin
          a_op = {8'b0, m_s};
          b_op = {1'b0, 17'h08000 - m_s};
        end
        4'd3, 4'd6: begin
          a_op = {9'b0, pv};
          b_op = {2'b0, pv};
        end
        4'd4, 4'd7: begin
          a_op = {9'b0, qv};
          b_op = 18'sd7373;
        end
        4'd8: begin
          a_op = {{8{cs_r[16]}}, cs_r};
          b_op = {2'b0, dt_r};
        end
        4'd9: begin
          a_op = {{8{sn_r[16]}}, sn_r};
          b_op = {2'b0, dt_r};
        end
        4'd10: begin
          a_op = {w_r.speed[23], w_r.speed};
          b_op = {2'b0, cdx_r[15:0]};
        end
        4'd11: begin
          a_op = {w_r.speed[23], w_r.speed};
          b_op = {{2{cdx_r[31]}}, cdx_r[31:16]};
        end
        4'd12: begin
          a_op = {w_r.speed[23], w_r.speed};
          b_op = {2'b0, cdy_r[15:0]};
        end
        4'd13: begin
          a_op = {w_r.speed[23], w_r.speed};
          b_op = {{2{cdy_r[31]}}, cdy_r[31:16]};
        end
        default: mul_en = 1'b0;
      endcase
    end else if (state_r == S_SPAWN) begin
      mul_en = 1'b1;
      case (st_r)
        4'd0: begin
          a_op = {9'b0, spread_r[15:0]};
          b_op = {2'b0, rx_r};
        end
        4'd1: begin
          a_op = {9'b0, spread_r[31:16]};
          b_op = {2'b0, ry_r};
        end
        4'd2: begin
          a_op = {{8{d_dir[16]}}, d_dir};
          b_op = {2'b0, rdir_r};
        end
        4'd3: begin
          a_op = {{8{d_acc[16]}}, d_acc};
          b_op = {2'b0, racc_r};
        end
        4'd4: begin
          a_op = {{8{d_vel[16]}}, d_vel};
          b_op = {2'b0, rvel_r};
        end
        4'd5: begin
          a_op = d_life;
          b_op = {2'b0, rlife_r};
        end
        default: mul_en = 1'b0;
      endcase
    end
  end

  // Sequencer: next state, working values and memory accesses.
  always_comb begin
    state_nxt = state_r;
    st_nxt    = st_r;
    idx_nxt   = idx_r;
    live_nxt  = live_r;
    acc_nxt   = acc_r;
    run_nxt   = run_r;
    drop_nxt  = drop_r;
    w_nxt     = w_r;
    p_nxt     = p_r;
    cs_nxt    = cs_r;
    sn_nxt    = sn_r;
    cdx_nxt   = cdx_r;
    cdy_nxt   = cdy_r;
    lo_nxt    = lo_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tlast_nxt  = out_tlast_r;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    mem_we    = 1'b0;
    mem_waddr = idx_r[SLOT_W-1:0];
    mem_wdata = w_r;
    mem_re    = 1'b0;
    mem_raddr = idx_r[SLOT_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          drop_nxt = 1'b0;
          idx_nxt  = '0;
          st_nxt   = '0;
          case (func_t'(in_tdata[2:0]))
            FN_TICK: begin
              state_nxt = (live_r == '0) ? S_EMIT_CHK : S_UPD_RD;
            end
            FN_EMIT: begin
              if (live_r < CNT_W'(POOL_DEPTH)) begin
                state_nxt = S_SPAWN;
              end else begin
                drop_nxt  = 1'b1;
                state_nxt = S_OUT_ONE;
              end
            end
            FN_START: begin
              run_nxt   = 1'b1;
              state_nxt = S_OUT_ONE;
            end
            FN_PAUSE: begin
              run_nxt   = 1'b0;
              state_nxt = S_OUT_ONE;
            end
            FN_STOP: begin
              run_nxt   = 1'b0;
              live_nxt  = '0;
              state_nxt = S_OUT_ONE;
            end
            default: state_nxt = S_OUT_ONE;
          endcase
        end
      end

      S_UPD_RD: begin
        mem_re    = 1'b1;
        st_nxt    = '0;
        state_nxt = S_UPD_CALC;
      end

      S_UPD_CALC: begin
        st_nxt = st_r + 4'd1;
        case (st_r)
          4'd0: begin
            w_nxt      = rd;
            w_nxt.life = (rd.life > {8'b0, dt_r}) ? (rd.life - {8'b0, dt_r}) : '0;
          end
          4'd2: w_nxt.speed = sat24(spd_w);
          4'd3, 4'd6: p_nxt = pv;
          4'd5: cs_nxt = ang_c[15] ? -signed'({1'b0, qv}) : signed'({1'b0, qv});
          4'd8: sn_nxt = w_r.angle[15] ? -signed'({1'b0, qv}) : signed'({1'b0, qv});
          4'd9: cdx_nxt = prod[31:0];
          4'd10: cdy_nxt = prod[31:0];
          4'd11, 4'd13: lo_nxt = prod;
          4'd12: w_nxt.x = sat24(32'(w_r.x) + 32'(dpos_w));
          4'd14: begin
            mem_we      = 1'b1;
            mem_wdata   = w_r;
            mem_wdata.y = sat24(32'(w_r.y) + 32'(dpos_w));
            if (idx_r + 1'b1 < live_r) begin
              idx_nxt   = idx_r + 1'b1;
              state_nxt = S_UPD_RD;
            end else begin
              idx_nxt   = '0;
              state_nxt = S_CMP_RD;
            end
          end
          default: ;
        endcase
      end

      // Swap-with-last removal; the refilled slot is checked again.
      S_CMP_RD: begin
        if (idx_r >= live_r) begin
          state_nxt = S_EMIT_CHK;
        end else begin
          mem_re    = 1'b1;
          state_nxt = S_CMP_CHK;
        end
      end

      S_CMP_CHK: begin
        if (rd.life == '0) begin
          if (idx_r == live_m1) begin
            live_nxt  = live_m1;
            state_nxt = S_CMP_RD;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = live_m1[SLOT_W-1:0];
            state_nxt = S_CMP_MOV;
          end
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_CMP_RD;
        end
      end

      S_CMP_MOV: begin
        mem_we    = 1'b1;
        mem_wdata = rd;
        live_nxt  = live_m1;
        state_nxt = S_CMP_RD;
      end

      S_EMIT_CHK: begin
        idx_nxt   = '0;
        st_nxt    = '0;
        state_nxt = (live_r == '0) ? S_OUT_ONE : S_OUT_RD;
        if (run_r) begin
          acc_nxt = acc_sat;
          if (acc_sat > {1'b0, period_r}) begin
            if (live_r < CNT_W'(POOL_DEPTH)) begin
              acc_nxt   = acc_sat - {1'b0, period_r};
              state_nxt = S_SPAWN;
            end else begin
              drop_nxt = 1'b1;
            end
          end
        end
      end

      S_SPAWN: begin
        st_nxt = st_r + 4'd1;
        case (st_r)
          4'd1: w_nxt.x = sat24(spx_w);
          4'd2: w_nxt.y = sat24(spy_w);
          4'd3: w_nxt.angle = dir_r[15:0] + draw_w[15:0];
          4'd4: w_nxt.accel = accel_span_r[15:0] + draw_w[15:0];
          4'd5: w_nxt.speed = {{4{vdraw[15]}}, vdraw, 4'b0};
          4'd6: begin
            mem_we         = 1'b1;
            mem_waddr      = live_r[SLOT_W-1:0];
            mem_wdata      = w_r;
            mem_wdata.life = life_span_r[23:0] + draw_w[23:0];
            live_nxt       = live_r + 1'b1;
            // A commanded emission reports only the new particle.
            idx_nxt        = (func_r == FN_EMIT) ? live_r : '0;
            state_nxt      = S_OUT_RD;
          end
          default: ;
        endcase
      end

      S_OUT_RD: begin
        mem_re    = 1'b1;
        state_nxt = S_OUT_LD;
      end

      S_OUT_LD: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_tlast_nxt  = (idx_r == live_m1);
          out_tdata_nxt  = {3'b0, live_r, rd.life, rd.y, rd.x, idx_r[SLOT_W-1:0]};
          out_tuser_nxt  = {drop_r, 1'b1};
          if (idx_r == live_m1) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_OUT_RD;
          end
        end
      end

      S_OUT_ONE: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_tlast_nxt  = 1'b1;
          out_tdata_nxt  = {3'b0, live_r, 78'b0};
          out_tuser_nxt  = {drop_r, 1'b0};
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      st_r         <= '0;
      idx_r        <= '0;
      live_r       <= '0;
      acc_r        <= '0;
      run_r        <= 1'b0;
      drop_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      st_r         <= st_nxt;
      idx_r        <= idx_nxt;
      live_r       <= live_nxt;
      acc_r        <= acc_nxt;
      run_r        <= run_nxt;
      drop_r       <= drop_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // Payload and working registers need no reset.
  always_ff @(posedge clk) begin
    w_r         <= w_nxt;
    p_r         <= p_nxt;
    cs_r        <= cs_nxt;
    sn_r        <= sn_nxt;
    cdx_r       <= cdx_nxt;
    cdy_r       <= cdy_nxt;
    lo_r        <= lo_nxt;
    out_tlast_r <= out_tlast_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
    if (in_tvalid && in_tready) begin
      func_r  <= in_tdata[2:0];
      dt_r    <= in_tdata[18:3];
      rx_r    <= in_tdata[34:19];
      ry_r    <= in_tdata[50:35];
      rdir_r  <= in_tdata[66:51];
      racc_r  <= in_tdata[82:67];
      rvel_r  <= in_tdata[98:83];
      rlife_r <= in_tdata[114:99];
    end
  end

  // Configuration writes; indices beyond the register list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      spread_r     <= '0;
      dir_r        <= 32'hFFFF0000;
      life_span_r  <= '0;
      accel_span_r <= '0;
      speed_span_r <= '0;
      period_r     <= 24'h010000;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_POSITION:  pos_r        <= cfg_data[31:0];
        CFG_SPREAD:    spread_r     <= cfg_data[31:0];
        CFG_DIRECTION: dir_r        <= cfg_data[31:0];
        CFG_LIFETIME:  life_span_r  <= cfg_data;
        CFG_ACCEL:     accel_span_r <= cfg_data[31:0];
        CFG_SPEED:     speed_span_r <= cfg_data[31:0];
        CFG_PERIOD:    period_r     <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  `PPTK_ASSERT(a_live_bound, clk, rst_n, live_r <= CNT_W'(POOL_DEPTH), "live count above pool depth")
  `PPTK_ASSERT(a_wr_in_pool, clk, rst_n, mem_we |-> ({1'b0, mem_waddr} <= live_r), "write beyond live slots")
  `PPTK_ASSERT_NEVER(a_open_item, clk, rst_n, out_tvalid_r && !out_tlast_r && state_r == S_IDLE, "idle with a non-final result pending")

endmodule

// ===== design/pptk_mul.sv =====
// ---------------------------------------------------------------------------
// Shared multiplier
// Signed multiplier with a registered product, shared by the update and spawn steps.
// ---------------------------------------------------------------------------
module pptk_mul
  import pptk_pkg::*;
(
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [MUL_A_W-1:0] a,
  input  logic signed [MUL_B_W-1:0] b,
  output logic signed [MUL_P_W-1:0] prod_r
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= MUL_P_W'(a) * MUL_P_W'(b);
    end
  end

endmodule

// ===== design/pptk_pool_mem.sv =====
// ---------------------------------------------------------------------------
// Particle memory
// One write port and one read port, read data registered and held.
// ---------------------------------------------------------------------------
module pptk_pool_mem
  import pptk_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [SLOT_W-1:0] waddr,
  input  part_t             wdata,
  input  logic              re,
  input  logic [SLOT_W-1:0] raddr,
  output part_t             rdata_r
);

  part_t mem [POOL_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

// ===== dv/pptk_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Particle pool checker
// Watches the command, result and register channels of the particle pool
// tick engine, keeps its own copy of the pool and queues the results that
// each accepted command must produce, then compares every result transfer.
// ---------------------------------------------------------------------------
module pptk_checker
  import pptk_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [119:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [87:0]  out_tdata,
  input  logic [1:0]   out_tuser,
  input  logic         out_tlast,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [47:0]  cfg_data,
  output int           fail_count,
  output int           pending
);

  typedef struct packed {
    logic [5:0]  slot;
    logic [23:0] pos_x;
    logic [23:0] pos_y;
    logic [23:0] life_left;
    logic [6:0]  live_count;
    logic        valid_res;
    logic        emit_dropped;
    logic        last;
  } pool_result_t;

  pool_result_t awaited_results[$];

  longint      px[POOL_DEPTH];
  longint      py[POOL_DEPTH];
  longint      spd[POOL_DEPTH];
  longint      acc[POOL_DEPTH];
  logic [15:0] ang[POOL_DEPTH];
  longint      life[POOL_DEPTH];
  int          live_n;
  longint      emit_acc;
  bit          running;

  logic [31:0] r_pos, r_spread, r_dir, r_accel, r_speed;
  logic [47:0] r_life;
  logic [23:0] r_period;

  assign pending = awaited_results.size();

  function automatic longint sx16(logic [15:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic longint ux(logic [23:0] v);
    return longint'({40'b0, v});
  endfunction

  function automatic longint sat24(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  // Parabolic sine approximation of a binary angle, Q1.15.
  function automatic longint sine_q15(logic [15:0] a);
    longint s, m, p, q;
    s = sx16(a);
    m = (s < 0) ? -s : s;
    p = (4 * m * (32768 - m)) >>> 15;
    q = p - ((p * p) >>> 15);
    p = p - ((7373 * q) >>> 15);
    return (s < 0) ? -p : p;
  endfunction

  // Pick a value between the span ends; the right shift floors.
  function automatic longint pick(longint lo, longint hi, logic [15:0] r);
    return lo + ((ux({8'b0, r}) * (hi - lo)) >>> 16);
  endfunction

  function automatic void spawn_particle(logic [119:0] d);
    longint ox, oy, a;
    ox = ux({8'b0, r_spread[15:0]});
    oy = ux({8'b0, r_spread[31:16]});
    px[live_n] = sat24(sx16(r_pos[15:0]) * 256 + ((ux({8'b0, d[34:19]}) * ox) >>> 7)
                       - ox * 256);
    py[live_n] = sat24(sx16(r_pos[31:16]) * 256 + ((ux({8'b0, d[50:35]}) * oy) >>> 7)
                       - oy * 256);
    a = pick(ux({8'b0, r_dir[15:0]}), ux({8'b0, r_dir[31:16]}), d[66:51]);
    ang[live_n]  = a[15:0];
    acc[live_n]  = pick(sx16(r_accel[15:0]), sx16(r_accel[31:16]), d[82:67]);
    spd[live_n]  = sat24(pick(sx16(r_speed[15:0]), sx16(r_speed[31:16]), d[98:83]) * 16);
    life[live_n] = pick(ux(r_life[23:0]), ux(r_life[47:24]), d[114:99]);
    live_n++;
  endfunction

  function automatic void queue_result(int slot, bit valid, bit dropped, bit last);
    pool_result_t r;
    longint x, y, l;
    r = '0;
    if (valid) begin
      x = px[slot];
      y = py[slot];
      l = life[slot];
      r.slot      = slot[5:0];
      r.pos_x     = x[23:0];
      r.pos_y     = y[23:0];
      r.life_left = l[23:0];
    end
    r.live_count   = live_n[6:0];
    r.valid_res    = valid;
    r.emit_dropped = dropped;
    r.last         = last;
    awaited_results.push_back(r);
  endfunction

  function automatic void advance_pool(logic [119:0] d);
    longint dt, s;
    int     i, tail;
    bit     dropped;
    dt = ux({8'b0, d[18:3]});
    dropped = 0;
    case (d[2:0])
      FN_TICK: begin
        for (i = 0; i < live_n; i++) begin
          life[i] = (life[i] > dt) ? life[i] - dt : 0;
          s = sat24(spd[i] + ((acc[i] * dt) >>> 12));
          spd[i] = s;
          px[i] = sat24(px[i] + ((s * sine_q15(ang[i] + 16'd16384) * dt) >>> 31));
          py[i] = sat24(py[i] + ((s * sine_q15(ang[i]) * dt) >>> 31));
        end
        // Dead entries are replaced by the last one and the slot looked at again.
        i = 0;
        while (i < live_n) begin
          if (life[i] == 0) begin
            tail = live_n - 1;
            px[i] = px[tail];  py[i] = py[tail];  spd[i] = spd[tail];
            acc[i] = acc[tail]; ang[i] = ang[tail]; life[i] = life[tail];
            live_n--;
          end else begin
            i++;
          end
        end
        if (running) begin
          emit_acc = emit_acc + dt;
          if (emit_acc > longint'(ACC_MAX)) emit_acc = longint'(ACC_MAX);
          if (emit_acc > ux(r_period)) begin
            if (live_n < POOL_DEPTH) begin
              spawn_particle(d);
              emit_acc -= ux(r_period);
            end else begin
              dropped = 1;
            end
          end
        end
        if (live_n == 0) begin
          queue_result(0, 0, dropped, 1);
        end else begin
          for (i = 0; i < live_n; i++) queue_result(i, 1, dropped, i + 1 == live_n);
        end
      end
      FN_EMIT: begin
        if (live_n < POOL_DEPTH) begin
          spawn_particle(d);
          queue_result(live_n - 1, 1, 0, 1);
        end else begin
          queue_result(0, 0, 1, 1);
        end
      end
      default: begin
        if (d[2:0] == FN_START) running = 1;
        if (d[2:0] == FN_PAUSE) running = 0;
        if (d[2:0] == FN_STOP) begin
          live_n  = 0;
          running = 0;
        end
        queue_result(0, 0, 0, 1);
      end
    endcase
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("result field %s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  function automatic void compare_result();
    pool_result_t w;
    if (awaited_results.size() == 0) begin
      $error("result transfer with nothing expected");
      fail_count++;
      return;
    end
    w = awaited_results.pop_front();
    check_field("slot",         w.slot,         out_tdata[5:0]);
    check_field("pos_x",        w.pos_x,        out_tdata[29:6]);
    check_field("pos_y",        w.pos_y,        out_tdata[53:30]);
    check_field("life_left",    w.life_left,    out_tdata[77:54]);
    check_field("live_count",   w.live_count,   out_tdata[84:78]);
    check_field("valid_res",    w.valid_res,    out_tuser[0]);
    check_field("emit_dropped", w.emit_dropped, out_tuser[1]);
    check_field("last",         w.last,         out_tlast);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      awaited_results.delete();
      fail_count = 0;
      live_n     = 0;
      emit_acc   = 0;
      running    = 0;
      r_pos      = '0;
      r_spread   = '0;
      r_dir      = 32'hFFFF0000;
      r_life     = '0;
      r_accel    = '0;
      r_speed    = '0;
      r_period   = 24'd65536;
    end else begin
      if (out_tvalid && out_tready) compare_result();
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_POSITION:  r_pos    = cfg_data[31:0];
          CFG_SPREAD:    r_spread = cfg_data[31:0];
          CFG_DIRECTION: r_dir    = cfg_data[31:0];
          CFG_LIFETIME:  r_life   = cfg_data;
          CFG_ACCEL:     r_accel  = cfg_data[31:0];
          CFG_SPEED:     r_speed  = cfg_data[31:0];
          CFG_PERIOD:    r_period = cfg_data[23:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) advance_pool(in_tdata);
    end
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Particle pool testbench
// Drives commands and register writes into the particle pool tick engine
// with bursty traffic and a stalling result receiver; the checker beside the
// block predicts and compares every result.
// ---------------------------------------------------------------------------
module tb_top
  import pptk_pkg::*;
();

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [119:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [87:0]  out_tdata;
  logic [1:0]   out_tuser;
  logic         out_tlast;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [2:0]   cfg_index;
  logic [47:0]  cfg_data;
  int           fail_count;
  int           pending;

  // Set by the stimulus to ask the receiver for one long hold-off.
  bit           hold_request;
  int           burst_left;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  particle_pool_tick_engine_unit dut (.*);

  pptk_checker checker_i (.*);

  // The run must end long before this; reaching it means the block hung.
  initial begin
    #20000000;
    $display("simulation failed");
    $finish;
  end

  // The receiver alternates stretches of steady acceptance with stretches of
  // random stalls, and serves a long hold-off when the stimulus asks for one.
  initial begin
    int  span;
    bit  steady;
    out_tready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request) begin
        out_tready <= 1'b0;
        repeat (3000) @(posedge clk);
        hold_request = 0;
      end else begin
        span   = $urandom_range(5, 60);
        steady = ($urandom_range(0, 2) == 0);
        repeat (span) begin
          out_tready <= steady ? 1'b1 : ($urandom_range(0, 3) != 0);
          @(posedge clk);
        end
      end
    end
  end

  // A register write happens only while nothing is in flight. Writes follow
  // each other back to back; the caller drops cfg_valid after the last one.
  task automatic write_reg(cfg_idx_t idx, logic [47:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Holds the sender back until every expected result has arrived, then
  // leaves room for the block to return to idle.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic configure(logic [31:0] pos, logic [31:0] spread, logic [31:0] dir,
                           logic [47:0] life, logic [31:0] accel,
                           logic [31:0] speed, logic [23:0] period);
    drain();
    write_reg(CFG_POSITION, {16'b0, pos});
    write_reg(CFG_SPREAD, {16'b0, spread});
    write_reg(CFG_DIRECTION, {16'b0, dir});
    write_reg(CFG_LIFETIME, life);
    write_reg(CFG_ACCEL, {16'b0, accel});
    write_reg(CFG_SPEED, {16'b0, speed});
    write_reg(CFG_PERIOD, {24'b0, period});
    cfg_valid <= 1'b0;
  endtask

  // One command transfer; a gap of random length opens before each burst.
  task automatic send(logic [2:0] func, logic [15:0] dt, logic [95:0] rnd);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                : $urandom_range(1, 8);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, rnd, dt, func};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
  endtask

  function automatic logic [95:0] any_fractions();
    return {$urandom, $urandom, $urandom};
  endfunction

  // Mostly ticks and emits, which keep the pool busy, with the odd control
  // command and unused code mixed in.
  task automatic send_random();
    int          pick;
    logic [2:0]  func;
    logic [15:0] dt;
    pick = $urandom_range(0, 99);
    if (pick < 45)      func = FN_TICK;
    else if (pick < 80) func = FN_EMIT;
    else if (pick < 88) func = FN_START;
    else if (pick < 93) func = FN_PAUSE;
    else if (pick < 97) func = FN_STOP;
    else                func = 3'($urandom_range(5, 7));
    dt = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20000));
    send(func, dt, any_fractions());
  endtask

  initial begin
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_POSITION;
    cfg_data     = '0;
    hold_request = 0;
    burst_left   = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    configure(32'h0000_0000, 32'h0100_0100, 32'hFFFF_0000, {24'h30000, 24'h08000},
              32'h0040_FFC0, 32'h0200_0010, 24'h8000);

    // Directed part: control codes, empty pool, extreme fractions and dt.
    send(FN_STOP, 16'h0000, '0);
    send(FN_TICK, 16'h0000, '0);
    send(FN_EMIT, 16'h0000, '0);
    send(FN_EMIT, 16'hFFFF, '1);
    send(FN_TICK, 16'hFFFF, '0);
    send(FN_TICK, 16'h0000, '1);
    send(FN_START, 16'h1234, '0);
    send(FN_TICK, 16'h9000, any_fractions());
    send(FN_TICK, 16'hFFFF, any_fractions());
    send(FN_PAUSE, 16'h0000, '0);
    send(FN_TICK, 16'h4000, '0);
    send(3'd5, 16'hFFFF, '1);
    send(3'd6, 16'h0000, '0);
    send(3'd7, 16'h5555, '1);
    send(FN_EMIT, 16'h0000, any_fractions());
    send(FN_STOP, 16'h0000, '0);
    send(FN_TICK, 16'h0100, '0);

    // Highest ends, reversed spans: positions and speeds saturate.
    configure(32'h7FFF_7FFF, 32'hFFFF_FFFF, 32'h0000_FFFF, {24'h000000, 24'hFFFFFF},
              32'h8000_7FFF, 32'h7FFF_7FFF, 24'hFFFFFF);
    send(FN_START, 16'h0000, '0);
    repeat (30) send_random();

    // Lowest ends: zero lifetime and zero period.
    configure(32'h8000_8000, 32'h0000_0000, 32'h0000_0000, 48'h0,
              32'h8000_8000, 32'h8000_8000, 24'h000000);
    send(FN_START, 16'h0000, '0);
    repeat (30) send_random();

    repeat (4) begin
      configure($urandom, $urandom, $urandom,
                {24'($urandom_range(0, 24'h60000)), 24'($urandom_range(0, 24'h20000))},
                $urandom, $urandom, 24'($urandom_range(1, 24'h20000)));
      repeat (30) send_random();
    end

    // Fill the pool to the top: explicit emits past the end are refused, and
    // timed emissions on a full pool are skipped. The receiver holds off
    // meanwhile so that the block backs up onto its input.
    configure($urandom, $urandom, $urandom, {24'hFFFFFF, 24'hF00000},
              $urandom, $urandom, 24'h000001);
    hold_request = 1;
    repeat (66) send(FN_EMIT, 16'($urandom), any_fractions());
    send(FN_START, 16'h0000, '0);
    repeat (3) send(FN_TICK, 16'($urandom_range(2, 100)), any_fractions());
    drain();
    send(FN_STOP, 16'h0000, '0);
    repeat (10) send_random();

    drain();
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
